// ----- rtl/core/ps2kbd_pkg.sv -----
package ps2kbd_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int QIDX_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

	localparam logic [31:0] GLITCH_RESET  = 32'd8000;
	localparam logic [31:0] TIMEOUT_RESET = 32'd19200;

	localparam logic [7:0] CODE_E0     = 8'hE0;
	localparam logic [7:0] CODE_E1     = 8'hE1;
	localparam logic [7:0] CODE_BREAK  = 8'hF0;
	localparam logic [7:0] CODE_ACK    = 8'hFA;
	localparam logic [7:0] CODE_RESEND = 8'hFE;
	localparam logic [7:0] CODE_BAT    = 8'hAA;

	localparam logic [9:0] PAUSE_HEAD = 10'h214;
	localparam logic [9:0] PAUSE_TAIL = 10'h077;

	localparam logic [3:0] RX_FRAME_BITS = 4'd11;
	localparam logic [3:0] TX_RELEASE    = 4'd10;

	typedef enum logic [1:0] {
		OP_EDGE   = 2'd0,
		OP_READ   = 2'd1,
		OP_SEND   = 2'd2,
		OP_CLRBAT = 2'd3
	} op_t;

	typedef enum logic {
		REG_GLITCH  = 1'b0,
		REG_TIMEOUT = 1'b1
	} reg_idx_t;

	// queue request from the control stage
	typedef struct packed {
		logic        push;
		logic        pop;
		logic [15:0] code;
	} q_req_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_stat_t;

	// per-word result fields known at accept time
	typedef struct packed {
		logic pop;
		logic drive_enable;
		logic drive_level;
		logic release_line;
		logic ack_flag;
		logic resend_flag;
		logic bat_flag;
		logic tx_busy;
	} res_t;

	function automatic logic [QIDX_W-1:0] next_idx(input logic [QIDX_W-1:0] i);
		logic [QIDX_W-1:0] r;
		if (i == QIDX_W'(QUEUE_DEPTH - 1)) begin
			r = '0;
		end else begin
			r = i + QIDX_W'(1);
		end
		return r;
	endfunction

endpackage

// ----- rtl/core/ps2_keyboard_host_receiver.sv -----
// pipeline: two register stages, stage 1 with the queue read in flight, then the
// output register m_tdata_q; throughput: one word per cycle while m_tready holds;
// the scan-code queue is a one-port-read, one-port-write memory with a registered
// read, and a pop never meets a push
// reset: arst_n clears all control state, flags, queue pointers and config
// registers to their defaults at once; queue contents are left unset
module ps2_keyboard_host_receiver (
	input  logic        clk,
	input  logic        arst_n,
	// config write port
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [31:0] cfg_wdata,
	// input words
	input  logic        s_tvalid,
	output logic        s_tready,
	// [1:0] operation, [33:2] edge_time, [34] data_bit, [42:35] send_byte, rest zero
	input  logic [47:0] s_tdata,
	// result words
	output logic        m_tvalid,
	input  logic        m_tready,
	// [15:0] read_code, [16] read_valid, [17] drive_enable, [18] drive_level,
	// [19] release_line, [20] ack_flag, [21] resend_flag, [22] bat_flag, [23] tx_busy
	output logic [23:0] m_tdata
);

	logic                accept;
	logic                out_free;
	ps2kbd_pkg::q_req_t  q_req;
	ps2kbd_pkg::q_stat_t q_stat;
	ps2kbd_pkg::res_t    res;
	logic [15:0]         rd_data;

	// stage 1: result fields known at accept, queue read in flight
	logic                valid_s1;
	ps2kbd_pkg::res_t    res_s1;

	// output register
	logic                m_tvalid_q;
	logic [23:0]         m_tdata_q;
	logic [15:0]         prev_read_q;

	logic [15:0]         popped;
	logic                pause_tail;

	// output register frees when empty or being taken; stage 1 then moves on
	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = !valid_s1 || out_free;
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	ps2kbd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.accept    (accept),
		.operation (ps2kbd_pkg::op_t'(s_tdata[1:0])),
		.edge_time (s_tdata[33:2]),
		.data_bit  (s_tdata[34]),
		.send_byte (s_tdata[42:35]),
		.q_stat    (q_stat),
		.q_req     (q_req),
		.res       (res)
	);

	ps2kbd_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (q_req),
		.stat    (q_stat),
		.rd_data (rd_data)
	);

	// pause sequence: the 0x77 tail after an E1 14 read comes back as zero
	always_comb begin
		pause_tail = (prev_read_q[9:0] == ps2kbd_pkg::PAUSE_HEAD)
			&& (rd_data[9:0] == ps2kbd_pkg::PAUSE_TAIL);
		popped = pause_tail ? 16'h0000 : rd_data;
	end

	// the read data register holds while stage 1 stalls since no pop is issued
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			m_tvalid_q  <= 1'b0;
			prev_read_q <= '0;
		end else begin
			if (s_tready) begin
				valid_s1 <= accept;
			end
			if (out_free) begin
				m_tvalid_q <= valid_s1;
				if (valid_s1 && res_s1.pop) begin
					prev_read_q <= popped;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1 <= res;
		end
		if (out_free && valid_s1) begin
			m_tdata_q <= {res_s1.tx_busy, res_s1.bat_flag, res_s1.resend_flag,
				res_s1.ack_flag, res_s1.release_line, res_s1.drive_level,
				res_s1.drive_enable, res_s1.pop,
				res_s1.pop ? popped : 16'h0000};
		end
	end

endmodule

// ----- rtl/core/ps2kbd_queue.sv -----
module ps2kbd_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ps2kbd_pkg::q_req_t    req,
	output ps2kbd_pkg::q_stat_t   stat,
	output logic [15:0]           rd_data
);

	logic [15:0] mem [ps2kbd_pkg::QUEUE_DEPTH];
	logic [ps2kbd_pkg::QIDX_W-1:0] head_q;
	logic [ps2kbd_pkg::QIDX_W-1:0] tail_q;
	logic [15:0] rd_data_q;

	assign stat.empty = (head_q == tail_q);
	assign stat.full  = (ps2kbd_pkg::next_idx(head_q) == tail_q);
	assign rd_data    = rd_data_q;

	// push and pop come from different words, never in the same cycle
	always_ff @(posedge clk) begin
		if (req.push) begin
			mem[head_q] <= req.code;
		end
		if (req.pop) begin
			rd_data_q <= mem[tail_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
		end else begin
			if (req.push) begin
				head_q <= ps2kbd_pkg::next_idx(head_q);
			end
			if (req.pop) begin
				tail_q <= ps2kbd_pkg::next_idx(tail_q);
			end
		end
	end

endmodule

// ----- rtl/core/ps2kbd_ctrl.sv -----
module ps2kbd_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [0:0]            cfg_index,
	input  logic [31:0]           cfg_wdata,
	input  logic                  accept,
	input  ps2kbd_pkg::op_t       operation,
	input  logic [31:0]           edge_time,
	input  logic                  data_bit,
	input  logic [7:0]            send_byte,
	input  ps2kbd_pkg::q_stat_t   q_stat,
	output ps2kbd_pkg::q_req_t    q_req,
	output ps2kbd_pkg::res_t      res
);

	logic [31:0] glitch_q, timeout_q, last_edge_q;
	logic [10:0] rx_frame_q;
	logic [3:0]  rx_cnt_q;
	logic        pre_e0_q, pre_e1_q, pre_brk_q;
	logic [8:0]  tx_frame_q;
	logic [3:0]  tx_cnt_q;
	logic        ack_q, resend_q, bat_q;

	logic [31:0] gap;
	logic        edge_ok, timeout;
	logic [10:0] frame_base, frame_set, rx_frame_d;
	logic [3:0]  cnt_base, cnt_inc, rx_cnt_d;
	logic [7:0]  code;
	logic        frame_good;
	logic        pre_e0_d, pre_e1_d, pre_brk_d;
	logic [8:0]  tx_frame_d;
	logic [3:0]  tx_cnt_d, tx_idx;
	logic        ack_d, resend_d, bat_d;
	logic        push;
	logic [15:0] tag_code;

	function automatic logic [3:0] cnt_next_tx(input logic [3:0] c);
		return c + 4'd1;
	endfunction

	always_comb begin
		gap        = edge_time - last_edge_q;
		edge_ok    = (operation == ps2kbd_pkg::OP_EDGE) && !(gap < glitch_q);
		timeout    = gap > timeout_q;
		frame_base = timeout ? '0 : rx_frame_q;
		cnt_base   = timeout ? '0 : rx_cnt_q;
		frame_set  = frame_base;
		if (cnt_base < ps2kbd_pkg::RX_FRAME_BITS && data_bit) begin
			frame_set = frame_base | (11'd1 << cnt_base);
		end
		cnt_inc    = cnt_base + 4'd1;
		code       = frame_set[8:1];
		frame_good = !frame_set[0] && frame_set[10] && (^frame_set[9:1]);
		tx_idx     = tx_cnt_q - 4'd1;

		tag_code = {8'h00, code};
		if (pre_e0_q) begin
			tag_code[8] = 1'b1;
		end else if (pre_e1_q) begin
			tag_code[9] = 1'b1;
		end
		tag_code[15] = pre_brk_q;

		rx_frame_d = rx_frame_q;
		rx_cnt_d   = rx_cnt_q;
		pre_e0_d   = pre_e0_q;
		pre_e1_d   = pre_e1_q;
		pre_brk_d  = pre_brk_q;
		tx_frame_d = tx_frame_q;
		tx_cnt_d   = tx_cnt_q;
		ack_d      = ack_q;
		resend_d   = resend_q;
		bat_d      = bat_q;
		push       = 1'b0;
		res        = '0;

		case (operation)
			ps2kbd_pkg::OP_EDGE: begin
				if (edge_ok) begin
					rx_frame_d = frame_base;
					rx_cnt_d   = cnt_base;
					if (tx_cnt_q != 4'd0) begin
						if (tx_cnt_q >= ps2kbd_pkg::TX_RELEASE) begin
							tx_frame_d       = '0;
							tx_cnt_d         = '0;
							res.release_line = 1'b1;
						end else begin
							res.drive_enable = 1'b1;
							res.drive_level  = tx_frame_q[tx_idx];
							tx_cnt_d         = cnt_next_tx(tx_cnt_q);
						end
					end else if (cnt_inc >= ps2kbd_pkg::RX_FRAME_BITS) begin
						rx_frame_d = '0;
						rx_cnt_d   = '0;
						if (frame_good) begin
							if (code == ps2kbd_pkg::CODE_E0) begin
								pre_e0_d = 1'b1;
							end else if (code == ps2kbd_pkg::CODE_E1) begin
								pre_e1_d = 1'b1;
							end else if (code == ps2kbd_pkg::CODE_BREAK) begin
								pre_brk_d = 1'b1;
							end else if (code == ps2kbd_pkg::CODE_ACK) begin
								ack_d = 1'b1;
							end else if (code == ps2kbd_pkg::CODE_RESEND) begin
								resend_d = 1'b1;
							end else if (code == ps2kbd_pkg::CODE_BAT) begin
								bat_d = 1'b1;
							end else begin
								// full queue drops the code but still clears prefixes
								push      = !q_stat.full;
								pre_e0_d  = 1'b0;
								pre_e1_d  = 1'b0;
								pre_brk_d = 1'b0;
							end
						end
					end else begin
						rx_frame_d = frame_set;
						rx_cnt_d   = cnt_inc;
					end
				end
			end
			ps2kbd_pkg::OP_READ: begin
				res.pop = !q_stat.empty;
			end
			ps2kbd_pkg::OP_SEND: begin
				ack_d      = 1'b0;
				resend_d   = 1'b0;
				tx_frame_d = {~(^send_byte), send_byte};
				tx_cnt_d   = 4'd1;
			end
			ps2kbd_pkg::OP_CLRBAT: begin
				bat_d = 1'b0;
			end
			default: begin
			end
		endcase

		res.ack_flag    = ack_d;
		res.resend_flag = resend_d;
		res.bat_flag    = bat_d;
		res.tx_busy     = (tx_cnt_d != 4'd0);

		q_req.push = accept && push;
		q_req.pop  = accept && res.pop;
		q_req.code = tag_code;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			glitch_q  <= ps2kbd_pkg::GLITCH_RESET;
			timeout_q <= ps2kbd_pkg::TIMEOUT_RESET;
		end else if (cfg_we) begin
			if (cfg_index == ps2kbd_pkg::REG_GLITCH) begin
				glitch_q <= cfg_wdata;
			end else begin
				timeout_q <= cfg_wdata;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_edge_q <= '0;
			rx_frame_q  <= '0;
			rx_cnt_q    <= '0;
			pre_e0_q    <= 1'b0;
			pre_e1_q    <= 1'b0;
			pre_brk_q   <= 1'b0;
			tx_frame_q  <= '0;
			tx_cnt_q    <= '0;
			ack_q       <= 1'b0;
			resend_q    <= 1'b0;
			bat_q       <= 1'b0;
		end else if (accept) begin
			if (edge_ok) begin
				last_edge_q <= edge_time;
			end
			rx_frame_q <= rx_frame_d;
			rx_cnt_q   <= rx_cnt_d;
			pre_e0_q   <= pre_e0_d;
			pre_e1_q   <= pre_e1_d;
			pre_brk_q  <= pre_brk_d;
			tx_frame_q <= tx_frame_d;
			tx_cnt_q   <= tx_cnt_d;
			ack_q      <= ack_d;
			resend_q   <= resend_d;
			bat_q      <= bat_d;
		end
	end

endmodule
